### rtl/dlds_pkg.sv
// Shared constants and dot-pattern lookup for the double lores dot serializer.
`default_nettype none
package dlds_pkg;

    localparam int DOTS_PER_CELL    = 7;
    localparam int DOTS_PER_COLUMN  = 2 * DOTS_PER_CELL;
    localparam int PAIRS_PER_COLUMN = DOTS_PER_COLUMN / 2;
    localparam int PAIR_CNT_W       = $clog2(PAIRS_PER_COLUMN);

    typedef logic [DOTS_PER_CELL-1:0]   cell_dots_t;
    typedef logic [DOTS_PER_COLUMN-1:0] row_dots_t;
    typedef logic [PAIR_CNT_W-1:0]      pair_cnt_t;

    localparam pair_cnt_t LAST_PAIR = pair_cnt_t'(PAIRS_PER_COLUMN - 1);

    // Entries 0..15 even columns, 16..31 the pattern rotated by two dots.
    localparam cell_dots_t CELL_DOTS [32] = '{
        7'h00, 7'h11, 7'h22, 7'h33, 7'h44, 7'h55, 7'h66, 7'h77,
        7'h08, 7'h19, 7'h2A, 7'h3B, 7'h4C, 7'h5D, 7'h6E, 7'h7F,
        7'h00, 7'h44, 7'h08, 7'h4C, 7'h11, 7'h55, 7'h19, 7'h5D,
        7'h22, 7'h66, 7'h2A, 7'h6E, 7'h33, 7'h77, 7'h3B, 7'h7F
    };

    function automatic cell_dots_t expand(input logic [3:0] nibble, input logic odd);
        return CELL_DOTS[{odd, nibble}];
    endfunction

endpackage
`default_nettype wire

### rtl/dlds_in_if.sv
// Column input channel: one text-memory column per word.
`default_nettype none
interface dlds_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] aux_byte;
    logic [7:0] main_byte;
    logic       odd_column;

    modport source (output valid, output aux_byte, output main_byte, output odd_column,
                    input ready);
    modport sink   (input valid, input aux_byte, input main_byte, input odd_column,
                    output ready);
endinterface
`default_nettype wire

### rtl/dlds_out_if.sv
// Dot-pair output channel: two dots of each cell row per word.
`default_nettype none
interface dlds_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] upper_dots;
    logic [1:0] lower_dots;
    logic       last_pair;

    modport source (output valid, output upper_dots, output lower_dots, output last_pair,
                    input ready);
    modport sink   (input valid, input upper_dots, input lower_dots, input last_pair,
                    output ready);
endinterface
`default_nettype wire

### rtl/double_lores_dot_serializer_core.sv
// Double lores column to monochrome dot-pair serializer, top level.
//
//  channel  dir  payload                                   handshake
//  column   in   aux_byte[8] main_byte[8] odd_column[1]    valid/ready
//  dots     out  upper_dots[2] lower_dots[2] last_pair[1]  valid/ready
//
// One column word yields seven dot-pair words. The next column is taken in the
// cycle its predecessor's last pair moves to the output register. The accepted
// column is registered in the shift registers, then its first pair moves to the
// output register. Reset clears the valid/busy flags only. A stall on dots
// holds the output register and the shift registers; no word is dropped.
`default_nettype none
module double_lores_dot_serializer_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dlds_in_if.sink     column,
    dlds_out_if.source  dots
);

    dlds_pkg::row_dots_t up_reg, up_next;
    dlds_pkg::row_dots_t lo_reg, lo_next;
    dlds_pkg::pair_cnt_t cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_up_reg, out_up_next;
    logic [1:0]          out_lo_reg, out_lo_next;
    logic                out_last_reg, out_last_next;

    logic advance;
    logic accept;
    logic at_last;

    assign at_last      = (cnt_reg == dlds_pkg::LAST_PAIR);
    assign advance      = busy_reg && (!out_valid_reg || dots.ready);
    assign column.ready = !busy_reg || (advance && at_last);
    assign accept       = column.valid && column.ready;

    always_comb
    begin
        up_next        = up_reg;
        lo_next        = lo_reg;
        cnt_next       = cnt_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && !dots.ready;
        out_up_next    = out_up_reg;
        out_lo_next    = out_lo_reg;
        out_last_next  = out_last_reg;

        if (advance)
        begin
            out_valid_next = 1'b1;
            out_up_next    = up_reg[1:0];
            out_lo_next    = lo_reg[1:0];
            out_last_next  = at_last;
            up_next        = up_reg >> 2;
            lo_next        = lo_reg >> 2;
            cnt_next       = cnt_reg + 1'b1;
            if (at_last)
                busy_next = 1'b0;
        end

        if (accept)
        begin
            // aux dots occupy the low half, so they leave first
            up_next   = {dlds_pkg::expand(column.main_byte[3:0], column.odd_column),
                         dlds_pkg::expand(column.aux_byte[3:0],  column.odd_column)};
            lo_next   = {dlds_pkg::expand(column.main_byte[7:4], column.odd_column),
                         dlds_pkg::expand(column.aux_byte[7:4],  column.odd_column)};
            cnt_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        up_reg       <= up_next;
        lo_reg       <= lo_next;
        cnt_reg      <= cnt_next;
        out_up_reg   <= out_up_next;
        out_lo_reg   <= out_lo_next;
        out_last_reg <= out_last_next;
    end

    assign dots.valid      = out_valid_reg;
    assign dots.upper_dots = out_up_reg;
    assign dots.lower_dots = out_lo_reg;
    assign dots.last_pair  = out_last_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (column.valid && column.ready) |=> (busy_reg && cnt_reg == '0))
        else $error("column accept did not start a new pair sequence");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (dots.valid && dots.ready && !dots.last_pair) |=> dots.valid)
        else $error("gap after a non-final dot pair");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg <= dlds_pkg::LAST_PAIR))
        else $error("pair counter out of range");

    a_no_accept_midway: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !at_last) |-> !column.ready)
        else $error("column taken before the last pair left");

endmodule
`default_nettype wire

### tb/sv/dot_pair_checker.sv
// Checker for the dot serializer: predicts the dot pairs of each column word and compares them.
`timescale 1ns / 1ps
module dot_pair_checker (
    input  logic clk,
    input  logic rst_n,
    dlds_in_if   column,
    dlds_out_if  dots,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        logic [1:0] upper;
        logic [1:0] lower;
        logic       last;
    } dot_pair_t;

    localparam int MAX_PRINTED = 40;

    dot_pair_t pairs_owed [$];
    dot_pair_t owed;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    // Dot i shows nibble bit (i mod 4); odd columns start two bits further on.
    function automatic dlds_pkg::cell_dots_t cell_pattern(input logic [3:0] nibble,
                                                          input logic odd);
        dlds_pkg::cell_dots_t pattern;
        int                   phase;
        phase = odd ? 2 : 0;
        for (int i = 0; i < dlds_pkg::DOTS_PER_CELL; i++)
        begin
            pattern[i] = nibble[(i + phase) % 4];
        end
        return pattern;
    endfunction

    task automatic queue_column_pairs(input logic [7:0] aux, input logic [7:0] mainb,
                                      input logic odd);
        dlds_pkg::row_dots_t upper_row;
        dlds_pkg::row_dots_t lower_row;
        dot_pair_t           pair;
        // aux dots on the left, main dots follow
        upper_row = {cell_pattern(mainb[3:0], odd), cell_pattern(aux[3:0], odd)};
        lower_row = {cell_pattern(mainb[7:4], odd), cell_pattern(aux[7:4], odd)};
        for (int k = 0; k < dlds_pkg::PAIRS_PER_COLUMN; k++)
        begin
            pair.upper = upper_row[2*k +: 2];
            pair.lower = lower_row[2*k +: 2];
            pair.last  = (k == dlds_pkg::PAIRS_PER_COLUMN - 1);
            pairs_owed.push_back(pair);
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTED)
        begin
            $display("%0t ns: mismatch: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (dots.valid && dots.ready)
            begin
                if (pairs_owed.size() == 0)
                begin
                    report_mismatch($sformatf("dot word with no column behind it: %0d %0d %0d",
                                              dots.upper_dots, dots.lower_dots, dots.last_pair));
                end
                else
                begin
                    owed = pairs_owed.pop_front();
                    if (dots.upper_dots !== owed.upper)
                        report_mismatch($sformatf("upper_dots got %b want %b",
                                                  dots.upper_dots, owed.upper));
                    if (dots.lower_dots !== owed.lower)
                        report_mismatch($sformatf("lower_dots got %b want %b",
                                                  dots.lower_dots, owed.lower));
                    if (dots.last_pair !== owed.last)
                        report_mismatch($sformatf("last_pair got %b want %b",
                                                  dots.last_pair, owed.last));
                end
            end
            if (column.valid && column.ready)
            begin
                queue_column_pairs(column.aux_byte, column.main_byte, column.odd_column);
            end
        end
        pending = pairs_owed.size();
    end

endmodule

### tb/sv/double_lores_dot_serializer_core_test.sv
// Testbench top for the double lores dot serializer: clock, reset, column stimulus, verdict.
`timescale 1ns / 1ps
module double_lores_dot_serializer_core_test;

    localparam int RANDOM_COLUMNS = 350;
    localparam int CALM_TAIL      = 60;
    localparam int HOLD_AT        = 60;
    localparam int LONG_HOLD      = 80;
    localparam int QUIET_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 20;

    logic clk;
    logic rst_n;
    logic gaps_on;
    logic stalls_on;
    logic long_hold;
    int   fail_count;
    int   pairs_pending;
    int   quiet_cycles;

    dlds_in_if  column_if();
    dlds_out_if dots_if();

    double_lores_dot_serializer_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .column (column_if),
        .dots   (dots_if)
    );

    dot_pair_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .column     (column_if),
        .dots       (dots_if),
        .fail_count (fail_count),
        .pending    (pairs_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Offer one column word at the falling edge, hold it until taken.
    task automatic send_column(input logic [7:0] aux, input logic [7:0] mainb, input logic odd);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            column_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        column_if.valid      <= 1'b1;
        column_if.aux_byte   <= aux;
        column_if.main_byte  <= mainb;
        column_if.odd_column <= odd;
        @(posedge clk);
        while (!column_if.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Dot receiver: random stall bursts, plus one long hold on request.
    initial
    begin
        dots_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                dots_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold     <= 1'b0;
                dots_if.ready <= 1'b1;
            end
            else if (stalls_on && $urandom_range(0, 4) == 0)
            begin
                dots_if.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                dots_if.ready <= 1'b1;
            end
            else
            begin
                dots_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (column_if.valid && column_if.ready) || (dots_if.valid && dots_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        column_if.valid      = 1'b0;
        column_if.aux_byte   = 8'h00;
        column_if.main_byte  = 8'h00;
        column_if.odd_column = 1'b0;
        rst_n     = 1'b0;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        long_hold = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // extremes and every nibble in every cell position
        send_column(8'h00, 8'h00, 1'b0);
        send_column(8'h00, 8'h00, 1'b1);
        send_column(8'hFF, 8'hFF, 1'b0);
        send_column(8'hFF, 8'hFF, 1'b1);
        for (int n = 0; n < 16; n++)
        begin
            send_column({4'(n), 4'(15 - n)}, {4'(15 - n), 4'(n)}, 1'(n % 2));
        end
        send_column(8'hA5, 8'h5A, 1'b1);
        send_column(8'h5A, 8'hA5, 1'b0);

        // sender pause until every owed pair is out
        column_if.valid <= 1'b0;
        wait (pairs_pending == 0);
        @(negedge clk);

        for (int i = 0; i < RANDOM_COLUMNS; i++)
        begin
            if (i == HOLD_AT)
                long_hold <= 1'b1;
            if (i == RANDOM_COLUMNS - CALM_TAIL)
            begin
                gaps_on   <= 1'b0;
                stalls_on <= 1'b0;
            end
            send_column(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
        end
        column_if.valid <= 1'b0;

        wait (pairs_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pairs_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
